FILE: sv/assert_macros.svh
// Assertion macros used by the top RTL file of the set operations engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/seo_pkg.sv
// ----------------------------------------------------------------------------
// seo_pkg
// Request and status codes and the probe control word of the set engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package seo_pkg;

	localparam logic [2:0] REQ_LOAD_A = 3'd0;
	localparam logic [2:0] REQ_LOAD_B = 3'd1;
	localparam logic [2:0] REQ_UNION  = 3'd2;
	localparam logic [2:0] REQ_INTER  = 3'd3;
	localparam logic [2:0] REQ_DIFF   = 3'd4;
	localparam logic [2:0] REQ_MEMBER = 3'd5;
	localparam logic [2:0] REQ_CLEAR  = 3'd6;

	localparam logic [2:0] ST_ELEM    = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_PRESENT = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_DROPPED = 3'd4;

	// Control word that travels with a probe key down the cell chain.
	typedef struct packed {
		logic vld;
		logic sel_b;
		logic found;
	} probe_ctl_t;

endpackage

`default_nettype wire

FILE: sv/seo_cell.sv
// ----------------------------------------------------------------------------
// seo_cell
// One chain cell: holds one element of set A and one of set B, compares the
// passing probe key against the selected one and hands the probe onward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seo_cell #(
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_a,
	input  wire logic                         wr_b,
	input  wire logic signed [ELEM_WIDTH-1:0] wr_data,
	input  wire logic                         live_a,
	input  wire logic                         live_b,
	input  wire seo_pkg::probe_ctl_t          ctl_in,
	input  wire logic signed [ELEM_WIDTH-1:0] key_in,
	output seo_pkg::probe_ctl_t               ctl_out,
	output logic signed [ELEM_WIDTH-1:0]      key_out,
	output logic signed [ELEM_WIDTH-1:0]      a_elem,
	output logic signed [ELEM_WIDTH-1:0]      b_elem
);

	logic signed [ELEM_WIDTH-1:0] a_q;
	logic signed [ELEM_WIDTH-1:0] b_q;
	seo_pkg::probe_ctl_t          ctl_q;
	logic signed [ELEM_WIDTH-1:0] key_q;
	logic                         hit;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_q <= wr_data;
		end
		if (wr_b) begin
			b_q <= wr_data;
		end
		key_q <= key_in;
	end

	// Only an occupied slot may match.
	always_comb begin
		if (ctl_in.sel_b) begin
			hit = live_b && (b_q == key_in);
		end else begin
			hit = live_a && (a_q == key_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.vld   <= ctl_in.vld;
			ctl_q.sel_b <= ctl_in.sel_b;
			ctl_q.found <= ctl_in.found || (ctl_in.vld && hit);
		end
	end

	assign ctl_out = ctl_q;
	assign key_out = key_q;
	assign a_elem  = a_q;
	assign b_elem  = b_q;

endmodule

`default_nettype wire

FILE: sv/set_operations_engine.sv
// ----------------------------------------------------------------------------
// set_operations_engine
// Two multisets held in a chain of cells, with union, intersection,
// difference and membership runs driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: requests enter on the input channel (in_valid / in_stall, fields
// req_type and value); result beats leave on the output channel (out_valid /
// out_stall, fields value_res, status and last). Every run of result beats
// ends with last high; an empty run is one beat with the empty status.
// Loads and clears give no beat, but a load into a full set gives one
// beat with the dropped status. Each membership test or each element
// compared during a set operation sends one probe down the SET_SIZE-cell
// chain, and the sequencer waits for the probe to leave the last cell
// before it decides; union also copies each element of A to the output.
// One request is worked on at a time: in_stall stays high from acceptance
// of an operation until its run is finished, and while a result beat waits.
// When the receiver stalls, the held result beat does not change and the
// sequencer pauses before producing the next beat.
// Reset empties both sets and clears the output; stored elements are not
// cleared and are only read again after they are rewritten.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_operations_engine #(
	parameter int SET_SIZE   = 32,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      value_res,
	output logic [2:0]              status,
	output logic                    last
);

`include "assert_macros.svh"

	localparam int CNT_W = $clog2(SET_SIZE + 1);
	localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(SET_SIZE);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_UNA    = 6'b000010,
		S_PROBE  = 6'b000100,
		S_WAIT   = 6'b001000,
		S_DECIDE = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [2:0]                   op_q;
	logic [CNT_W-1:0]             j_q;
	logic [CNT_W-1:0]             count_a_q;
	logic [CNT_W-1:0]             count_b_q;
	logic                         pend_v_q;
	logic signed [ELEM_WIDTH-1:0] pend_q;
	logic signed [ELEM_WIDTH-1:0] key_q;
	logic                         found_q;
	logic                         out_valid_q;
	logic signed [31:0]           res_q;
	logic [2:0]                   status_q;
	logic                         last_q;

	logic                         in_acc;
	logic                         out_free;
	logic signed [ELEM_WIDTH-1:0] elem_in;
	logic [CNT_W-1:0]             lim;
	logic                         launch;
	logic signed [ELEM_WIDTH-1:0] launch_key;
	logic                         keep;

	seo_pkg::probe_ctl_t          ctl_w [SET_SIZE+1];
	logic signed [ELEM_WIDTH-1:0] key_w [SET_SIZE+1];
	logic signed [ELEM_WIDTH-1:0] a_elem [SET_SIZE];
	logic signed [ELEM_WIDTH-1:0] b_elem [SET_SIZE];
	logic [SET_SIZE-1:0]          probe_vld;

	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign elem_in  = ELEM_WIDTH'(value);
	assign lim      = (op_q == seo_pkg::REQ_UNION) ? count_b_q : count_a_q;
	assign keep     = (op_q == seo_pkg::REQ_INTER) ? found_q : !found_q;

	// A probe starts at a membership request or at each element that a set operation compares.
	always_comb begin
		launch     = 1'b0;
		launch_key = elem_in;
		if (state_q == S_IDLE) begin
			launch = in_acc && (req_type == seo_pkg::REQ_MEMBER);
		end else if (state_q == S_PROBE) begin
			launch = j_q < lim;
			if (op_q == seo_pkg::REQ_UNION) begin
				launch_key = b_elem[j_q[IDX_W-1:0]];
			end else begin
				launch_key = a_elem[j_q[IDX_W-1:0]];
			end
		end
	end

	assign ctl_w[0].vld   = launch;
	assign ctl_w[0].sel_b = (state_q == S_PROBE) && (op_q != seo_pkg::REQ_UNION);
	assign ctl_w[0].found = 1'b0;
	assign key_w[0]       = launch_key;

	for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
		logic wr_a;
		logic wr_b;
		assign wr_a = in_acc && (req_type == seo_pkg::REQ_LOAD_A)
			&& (count_a_q == CNT_W'(i));
		assign wr_b = in_acc && (req_type == seo_pkg::REQ_LOAD_B)
			&& (count_b_q == CNT_W'(i));
		assign probe_vld[i] = ctl_w[i+1].vld;

		seo_cell #(
			.ELEM_WIDTH(ELEM_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_a    (wr_a),
			.wr_b    (wr_b),
			.wr_data (elem_in),
			.live_a  (CNT_W'(i) < count_a_q),
			.live_b  (CNT_W'(i) < count_b_q),
			.ctl_in  (ctl_w[i]),
			.key_in  (key_w[i]),
			.ctl_out (ctl_w[i+1]),
			.key_out (key_w[i+1]),
			.a_elem  (a_elem[i]),
			.b_elem  (b_elem[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= seo_pkg::REQ_CLEAR;
			j_q         <= '0;
			count_a_q   <= '0;
			count_b_q   <= '0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			key_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			status_q    <= seo_pkg::ST_ELEM;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req_type)
							seo_pkg::REQ_LOAD_A: begin
								if (count_a_q < FULL) begin
									count_a_q <= count_a_q + CNT_W'(1);
								end else begin
									out_valid_q <= 1'b1;
									res_q       <= 32'(elem_in);
									status_q    <= seo_pkg::ST_DROPPED;
									last_q      <= 1'b1;
								end
							end
							seo_pkg::REQ_LOAD_B: begin
								if (count_b_q < FULL) begin
									count_b_q <= count_b_q + CNT_W'(1);
								end else begin
									out_valid_q <= 1'b1;
									res_q       <= 32'(elem_in);
									status_q    <= seo_pkg::ST_DROPPED;
									last_q      <= 1'b1;
								end
							end
							seo_pkg::REQ_UNION: begin
								op_q     <= req_type;
								j_q      <= '0;
								pend_v_q <= 1'b0;
								state_q  <= S_UNA;
							end
							seo_pkg::REQ_INTER, seo_pkg::REQ_DIFF: begin
								op_q     <= req_type;
								j_q      <= '0;
								pend_v_q <= 1'b0;
								state_q  <= S_PROBE;
							end
							seo_pkg::REQ_MEMBER: begin
								op_q    <= req_type;
								key_q   <= elem_in;
								state_q <= S_WAIT;
							end
							seo_pkg::REQ_CLEAR: begin
								count_a_q <= '0;
								count_b_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_UNA: begin
					// Copy all of A; each element waits in the pending slot so that
					// the final beat of the run can be marked.
					if (j_q < count_a_q) begin
						if (!pend_v_q || out_free) begin
							if (pend_v_q) begin
								out_valid_q <= 1'b1;
								res_q       <= 32'(pend_q);
								status_q    <= seo_pkg::ST_ELEM;
								last_q      <= 1'b0;
							end
							pend_q   <= a_elem[j_q[IDX_W-1:0]];
							pend_v_q <= 1'b1;
							j_q      <= j_q + CNT_W'(1);
						end
					end else begin
						j_q     <= '0;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (j_q < lim) begin
						key_q   <= launch_key;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_WAIT: begin
					if (ctl_w[SET_SIZE].vld) begin
						found_q <= ctl_w[SET_SIZE].found;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (op_q == seo_pkg::REQ_MEMBER) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							res_q       <= 32'(key_q);
							status_q    <= found_q ? seo_pkg::ST_PRESENT : seo_pkg::ST_ABSENT;
							last_q      <= 1'b1;
							state_q     <= S_IDLE;
						end
					end else if (!keep) begin
						j_q     <= j_q + CNT_W'(1);
						state_q <= S_PROBE;
					end else if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_valid_q <= 1'b1;
							res_q       <= 32'(pend_q);
							status_q    <= seo_pkg::ST_ELEM;
							last_q      <= 1'b0;
						end
						pend_q   <= key_q;
						pend_v_q <= 1'b1;
						j_q      <= j_q + CNT_W'(1);
						state_q  <= S_PROBE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q       <= pend_v_q ? 32'(pend_q) : '0;
						status_q    <= pend_v_q ? seo_pkg::ST_ELEM : seo_pkg::ST_EMPTY;
						last_q      <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = res_q;
	assign status    = status_q;
	assign last      = last_q;

	`AST_IMPLY(a_count_a_range, clk, arst_n, 1'b1, count_a_q <= FULL)
	`AST_IMPLY(a_count_b_range, clk, arst_n, 1'b1, count_b_q <= FULL)
	`AST_IMPLY(a_one_probe, clk, arst_n, 1'b1, $countones(probe_vld) <= 1)
	`AST_IMPLY(a_exit_in_wait, clk, arst_n, ctl_w[SET_SIZE].vld, state_q == S_WAIT)
	`AST_NEXT(a_launch_waits, clk, arst_n, launch, state_q == S_WAIT)
	`AST_IMPLY(a_empty_is_last, clk, arst_n,
		out_valid_q && (status_q == seo_pkg::ST_EMPTY), last_q)

endmodule

`default_nettype wire
